// ===== design/rbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rbp_pkg;

    localparam int NORM_W        = 16;
    localparam int DFRAC_W       = 16;
    localparam int MIN_DEN_SHIFT = 6;
    localparam int CFG_ADDR_W    = 6;
    localparam int CFG_DATA_W    = 64;

    typedef enum logic [2:0] {
        REG_NORMAL   = 3'd0,
        REG_POINT    = 3'd1,
        REG_BOX_MIN  = 3'd2,
        REG_BOX_MAX  = 3'd3,
        REG_MIN_DEN  = 3'd4,
        REG_MIN_DIST = 3'd5,
        REG_MARGIN   = 3'd6
    } t_reg_idx;

    localparam logic [15:0] MIN_DEN_RST  = 16'd655;
    localparam logic [15:0] MIN_DIST_RST = 16'd655;
    localparam logic [7:0]  MARGIN_RST   = 8'd1;

endpackage
`default_nettype wire

// ===== design/rbp_ray_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rbp_ray_if #(
    parameter int CW = 16,
    parameter int DW = 32
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic [DW-1:0]        best_distance;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, best_distance,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, best_distance,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/rbp_hit_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rbp_hit_if #(
    parameter int CW = 16,
    parameter int DW = 32
) ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [DW-1:0]        new_distance;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;

    modport source (
        output valid, hit, new_distance, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, hit, new_distance, point_x, point_y, point_z,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/rbp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbp_cfg #(
    parameter int CW = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rbp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [rbp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [rbp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                    pready,
    output logic      [3*rbp_pkg::NORM_W-1:0]       o_normal,
    output logic      [3*CW-1:0]                    o_point,
    output logic      [3*CW-1:0]                    o_box_min,
    output logic      [3*CW-1:0]                    o_box_max,
    output logic      [15:0]                        o_min_den,
    output logic      [15:0]                        o_min_dist,
    output logic      [7:0]                         o_margin
);
    logic [3*rbp_pkg::NORM_W-1:0] r_normal;
    logic [3*CW-1:0]              r_point;
    logic [3*CW-1:0]              r_box_min;
    logic [3*CW-1:0]              r_box_max;
    logic [15:0]                  r_min_den;
    logic [15:0]                  r_min_dist;
    logic [7:0]                   r_margin;
    rbp_pkg::t_reg_idx            idx;
    logic                         wr;

    assign idx = rbp_pkg::t_reg_idx'(paddr[5:3]);
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal   <= '0;
            r_point    <= '0;
            r_box_min  <= '0;
            r_box_max  <= '0;
            r_min_den  <= rbp_pkg::MIN_DEN_RST;
            r_min_dist <= rbp_pkg::MIN_DIST_RST;
            r_margin   <= rbp_pkg::MARGIN_RST;
        end else if (wr) begin
            case (idx)
                rbp_pkg::REG_NORMAL:   r_normal   <= pwdata[3*rbp_pkg::NORM_W-1:0];
                rbp_pkg::REG_POINT:    r_point    <= pwdata[3*CW-1:0];
                rbp_pkg::REG_BOX_MIN:  r_box_min  <= pwdata[3*CW-1:0];
                rbp_pkg::REG_BOX_MAX:  r_box_max  <= pwdata[3*CW-1:0];
                rbp_pkg::REG_MIN_DEN:  r_min_den  <= pwdata[15:0];
                rbp_pkg::REG_MIN_DIST: r_min_dist <= pwdata[15:0];
                rbp_pkg::REG_MARGIN:   r_margin   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            rbp_pkg::REG_NORMAL:   prdata = rbp_pkg::CFG_DATA_W'(r_normal);
            rbp_pkg::REG_POINT:    prdata = rbp_pkg::CFG_DATA_W'(r_point);
            rbp_pkg::REG_BOX_MIN:  prdata = rbp_pkg::CFG_DATA_W'(r_box_min);
            rbp_pkg::REG_BOX_MAX:  prdata = rbp_pkg::CFG_DATA_W'(r_box_max);
            rbp_pkg::REG_MIN_DEN:  prdata = rbp_pkg::CFG_DATA_W'(r_min_den);
            rbp_pkg::REG_MIN_DIST: prdata = rbp_pkg::CFG_DATA_W'(r_min_dist);
            rbp_pkg::REG_MARGIN:   prdata = rbp_pkg::CFG_DATA_W'(r_margin);
            default:               prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign o_normal   = r_normal;
    assign o_point    = r_point;
    assign o_box_min  = r_box_min;
    assign o_box_max  = r_box_max;
    assign o_min_den  = r_min_den;
    assign o_min_dist = r_min_dist;
    assign o_margin   = r_margin;
endmodule
`default_nettype wire

// ===== design/rbp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbp_front #(
    parameter int CW = 16,
    parameter int DW = 32,
    localparam int NUM_W = CW + 19,
    localparam int DEN_W = CW + 18,
    localparam int NW    = NUM_W + rbp_pkg::DFRAC_W
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic signed [CW-1:0]         i_org [3],
    input  wire logic signed [CW-1:0]         i_dir [3],
    input  wire logic        [DW-1:0]         i_best,
    input  wire logic [3*rbp_pkg::NORM_W-1:0] i_normal,
    input  wire logic [3*CW-1:0]              i_point,
    input  wire logic [15:0]                  i_min_den,
    output logic                              o_valid,
    output logic             [NW-1:0]         o_dividend,
    output logic             [DEN_W-1:0]      o_divisor,
    output logic                              o_ok,
    output logic                              o_sat,
    output logic signed      [CW-1:0]         o_org [3],
    output logic signed      [CW-1:0]         o_dir [3],
    output logic             [DW-1:0]         o_best
);
    localparam int NP   = CW + 17;
    localparam int DP   = CW + 16;
    localparam int CMPW = DEN_W + DW - rbp_pkg::DFRAC_W;

    logic signed [rbp_pkg::NORM_W-1:0] nrm [3];
    logic signed [CW-1:0]              pnt [3];
    logic                              nrm_nz;

    logic                 r1_v, r2_v, r3_v, r4_v, r5_v;
    logic signed [CW:0]   r1_diff [3];
    logic signed [NP-1:0] r2_pn [3];
    logic signed [DP-1:0] r2_pd [3];
    logic signed [NUM_W-1:0] r3_num, n3_num;
    logic signed [DEN_W-1:0] r3_den, n3_den;
    logic [NUM_W-1:0]     r4_anum, r5_anum;
    logic [DEN_W-1:0]     r4_aden, r5_aden;
    logic                 r4_ok, r5_ok, r5_sat;
    logic signed [CW-1:0] r1_o [3], r2_o [3], r3_o [3], r4_o [3], r5_o [3];
    logic signed [CW-1:0] r1_d [3], r2_d [3], r3_d [3], r4_d [3], r5_d [3];
    logic [DW-1:0]        r1_b, r2_b, r3_b, r4_b, r5_b;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            nrm[a] = $signed(i_normal[a*rbp_pkg::NORM_W +: rbp_pkg::NORM_W]);
            pnt[a] = $signed(i_point[a*CW +: CW]);
        end
        nrm_nz = (i_normal != '0);
        n3_num = -(NUM_W'(r2_pn[0]) + NUM_W'(r2_pn[1]) + NUM_W'(r2_pn[2]));
        n3_den = DEN_W'(r2_pd[0]) + DEN_W'(r2_pd[1]) + DEN_W'(r2_pd[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r1_diff[a] <= (CW+1)'(i_org[a]) - (CW+1)'(pnt[a]);
                r2_pn[a]   <= nrm[a] * r1_diff[a];
                r2_pd[a]   <= nrm[a] * r1_d[a];
                r1_o[a] <= i_org[a];
                r2_o[a] <= r1_o[a];
                r3_o[a] <= r2_o[a];
                r4_o[a] <= r3_o[a];
                r5_o[a] <= r4_o[a];
                r1_d[a] <= i_dir[a];
                r2_d[a] <= r1_d[a];
                r3_d[a] <= r2_d[a];
                r4_d[a] <= r3_d[a];
                r5_d[a] <= r4_d[a];
            end
            r1_b <= i_best;
            r2_b <= r1_b;
            r3_b <= r2_b;
            r4_b <= r3_b;
            r5_b <= r4_b;

            r3_num <= n3_num;
            r3_den <= n3_den;

            r4_anum <= r3_num[NUM_W-1] ? $unsigned(-r3_num) : $unsigned(r3_num);
            r4_aden <= r3_den[DEN_W-1] ? $unsigned(-r3_den) : $unsigned(r3_den);
            r4_ok   <= nrm_nz && !((r3_num != '0) && (r3_num[NUM_W-1] != r3_den[DEN_W-1]));

            r5_anum <= r4_anum;
            r5_aden <= r4_aden;
            r5_ok   <= r4_ok && (r4_aden != '0)
                       && (r4_aden >= DEN_W'({i_min_den, {rbp_pkg::MIN_DEN_SHIFT{1'b0}}}));
            r5_sat  <= CMPW'(r4_anum)
                       >= CMPW'({r4_aden, {(DW-rbp_pkg::DFRAC_W){1'b0}}});
        end
    end

    assign o_valid    = r5_v;
    assign o_dividend = {r5_anum, {rbp_pkg::DFRAC_W{1'b0}}};
    assign o_divisor  = r5_aden;
    assign o_ok       = r5_ok;
    assign o_sat      = r5_sat;
    assign o_org      = r5_o;
    assign o_dir      = r5_d;
    assign o_best     = r5_b;
endmodule
`default_nettype wire

// ===== design/rbp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbp_div #(
    parameter int NW  = 51,
    parameter int DVW = 34,
    parameter int QW  = 32,
    parameter int SW  = 130
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [NW-1:0]  i_dividend,
    input  wire logic [DVW-1:0] i_divisor,
    input  wire logic [SW-1:0]  i_side,
    output logic                o_valid,
    output logic      [QW-1:0]  o_quot,
    output logic      [SW-1:0]  o_side
);
    localparam int RW = DVW + QW;

    logic           s_v    [QW+1];
    logic [RW-1:0]  s_rem  [QW+1];
    logic [DVW-1:0] s_den  [QW+1];
    logic [QW-1:0]  s_q    [QW+1];
    logic [SW-1:0]  s_side [QW+1];

    assign s_v[0]    = i_valid;
    assign s_rem[0]  = RW'(i_dividend);
    assign s_den[0]  = i_divisor;
    assign s_q[0]    = '0;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic           r_v;
        logic [RW-1:0]  r_rem;
        logic [DVW-1:0] r_den;
        logic [QW-1:0]  r_q;
        logic [SW-1:0]  r_side;
        logic [RW-1:0]  sh;
        logic           ge;

        assign sh = RW'(s_den[k]) << B;
        assign ge = s_rem[k] >= sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? s_rem[k] - sh : s_rem[k];
                r_den  <= s_den[k];
                r_q    <= s_q[k] | (QW'(ge) << B);
                r_side <= s_side[k];
            end
        end

        assign s_v[k+1]    = r_v;
        assign s_rem[k+1]  = r_rem;
        assign s_den[k+1]  = r_den;
        assign s_q[k+1]    = r_q;
        assign s_side[k+1] = r_side;
    end

    assign o_valid = s_v[QW];
    assign o_quot  = s_q[QW];
    assign o_side  = s_side[QW];
endmodule
`default_nettype wire

// ===== design/rbp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbp_back #(
    parameter int CW = 16,
    parameter int DW = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [DW-1:0]        i_quot,
    input  wire logic                 i_ok,
    input  wire logic                 i_sat,
    input  wire logic signed [CW-1:0] i_org [3],
    input  wire logic signed [CW-1:0] i_dir [3],
    input  wire logic [DW-1:0]        i_best,
    input  wire logic [3*CW-1:0]      i_box_min,
    input  wire logic [3*CW-1:0]      i_box_max,
    input  wire logic [15:0]          i_min_dist,
    input  wire logic [7:0]           i_margin,
    output logic                      o_valid,
    output logic                      o_hit,
    output logic [DW-1:0]             o_dist,
    output logic signed [CW-1:0]      o_pt [3]
);
    localparam int PW   = CW + DW + 1;
    localparam int PT_W = PW - 15;

    logic [DW-1:0]          t1;
    logic signed [CW:0]     lo [3];
    logic signed [CW:0]     hi [3];
    logic signed [CW-1:0]   cmax, cmin;
    logic                   inbox;
    logic                   hit3;

    logic                   r1_v, r2_v, r3_v;
    logic                   r1_ok, r2_ok;
    logic [DW-1:0]          r1_t, r2_t;
    logic [DW-1:0]          r1_b, r2_b;
    logic signed [PW-1:0]   r1_prod [3];
    logic signed [CW-1:0]   r1_o [3];
    logic signed [PT_W-1:0] r2_pt [3];
    logic                   r3_hit;
    logic [DW-1:0]          r3_dist;
    logic signed [CW-1:0]   r3_pt [3];

    assign cmax = $signed({1'b0, {(CW-1){1'b1}}});
    assign cmin = $signed({1'b1, {(CW-1){1'b0}}});

    always_comb begin
        t1 = i_sat ? '1 : i_quot;
        inbox = 1'b1;
        for (int a = 0; a < 3; a++) begin
            lo[a] = (CW+1)'($signed(i_box_min[a*CW +: CW])) - $signed((CW+1)'(i_margin));
            hi[a] = (CW+1)'($signed(i_box_max[a*CW +: CW])) + $signed((CW+1)'(i_margin));
            if (r2_pt[a] < PT_W'(lo[a]) || r2_pt[a] > PT_W'(hi[a])) begin
                inbox = 1'b0;
            end
        end
        hit3 = r2_ok && inbox && (r2_b > r2_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t  <= t1;
            r1_ok <= i_ok && (t1 >= DW'(i_min_dist));
            r1_b  <= i_best;
            r2_t  <= r1_t;
            r2_ok <= r1_ok;
            r2_b  <= r1_b;
            for (int a = 0; a < 3; a++) begin
                r1_prod[a] <= PW'(i_dir[a]) * $signed({1'b0, t1});
                r1_o[a]    <= i_org[a];
                r2_pt[a]   <= PT_W'(r1_o[a])
                              + PT_W'((r1_prod[a] + PW'(32768)) >>> rbp_pkg::DFRAC_W);
                if (!hit3) begin
                    r3_pt[a] <= '0;
                end else if (r2_pt[a] > PT_W'(cmax)) begin
                    r3_pt[a] <= cmax;
                end else if (r2_pt[a] < PT_W'(cmin)) begin
                    r3_pt[a] <= cmin;
                end else begin
                    r3_pt[a] <= r2_pt[a][CW-1:0];
                end
            end
            r3_hit  <= hit3;
            r3_dist <= hit3 ? r2_t : r2_b;
        end
    end

    assign o_valid = r3_v;
    assign o_hit   = r3_hit;
    assign o_dist  = r3_dist;
    assign o_pt    = r3_pt;
endmodule
`default_nettype wire

// ===== design/ray_bounded_plane_intersect.sv =====
// Pipeline depth: DW + 8 register stages (40 at DW = 32).
// Throughput: one item per cycle unless stalled; a divider of DW restoring stages,
// one quotient bit per stage, between five front stages and three back stages.
// The whole pipeline holds while a finished result waits on the output.
// Synchronous active-low reset clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module ray_bounded_plane_intersect #(
    parameter int COORD_WIDTH = 16,
    parameter int DIST_WIDTH  = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rbp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [rbp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [rbp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    rbp_ray_if.sink                               i_ray,
    rbp_hit_if.source                             o_hit
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = DIST_WIDTH;
    localparam int NUM_W = CW + 19;
    localparam int DEN_W = CW + 18;
    localparam int NW    = NUM_W + rbp_pkg::DFRAC_W;
    localparam int SW    = 6 * CW + DW + 2;

    logic [3*rbp_pkg::NORM_W-1:0] normal;
    logic [3*CW-1:0]              point, box_min, box_max;
    logic [15:0]                  min_den, min_dist;
    logic [7:0]                   margin;
    logic                         en;

    logic signed [CW-1:0] in_o [3];
    logic signed [CW-1:0] in_d [3];
    logic                 f_v, f_ok, f_sat;
    logic [NW-1:0]        f_dividend;
    logic [DEN_W-1:0]     f_divisor;
    logic signed [CW-1:0] f_o [3];
    logic signed [CW-1:0] f_d [3];
    logic [DW-1:0]        f_b;
    logic [SW-1:0]        f_side, d_side;
    logic                 d_v;
    logic [DW-1:0]        d_q;
    logic signed [CW-1:0] d_o [3];
    logic signed [CW-1:0] d_d [3];
    logic [DW-1:0]        d_b;
    logic                 d_ok, d_sat;
    logic                 b_v;
    logic signed [CW-1:0] b_pt [3];

    rbp_cfg #(.CW(CW)) u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .o_normal(normal), .o_point(point), .o_box_min(box_min), .o_box_max(box_max),
        .o_min_den(min_den), .o_min_dist(min_dist), .o_margin(margin)
    );

    assign en          = !b_v || o_hit.ready;
    assign i_ray.ready = en;

    assign in_o[0] = i_ray.origin_x;
    assign in_o[1] = i_ray.origin_y;
    assign in_o[2] = i_ray.origin_z;
    assign in_d[0] = i_ray.dir_x;
    assign in_d[1] = i_ray.dir_y;
    assign in_d[2] = i_ray.dir_z;

    rbp_front #(.CW(CW), .DW(DW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(i_ray.valid), .i_org(in_o), .i_dir(in_d), .i_best(i_ray.best_distance),
        .i_normal(normal), .i_point(point), .i_min_den(min_den),
        .o_valid(f_v), .o_dividend(f_dividend), .o_divisor(f_divisor),
        .o_ok(f_ok), .o_sat(f_sat), .o_org(f_o), .o_dir(f_d), .o_best(f_b)
    );

    assign f_side = {f_ok, f_sat, f_b, f_d[2], f_d[1], f_d[0], f_o[2], f_o[1], f_o[0]};

    rbp_div #(.NW(NW), .DVW(DEN_W), .QW(DW), .SW(SW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(f_v), .i_dividend(f_dividend), .i_divisor(f_divisor), .i_side(f_side),
        .o_valid(d_v), .o_quot(d_q), .o_side(d_side)
    );

    assign {d_ok, d_sat, d_b, d_d[2], d_d[1], d_d[0], d_o[2], d_o[1], d_o[0]} = d_side;

    rbp_back #(.CW(CW), .DW(DW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(d_v), .i_quot(d_q), .i_ok(d_ok), .i_sat(d_sat),
        .i_org(d_o), .i_dir(d_d), .i_best(d_b),
        .i_box_min(box_min), .i_box_max(box_max), .i_min_dist(min_dist), .i_margin(margin),
        .o_valid(b_v), .o_hit(o_hit.hit), .o_dist(o_hit.new_distance), .o_pt(b_pt)
    );

    assign o_hit.valid   = b_v;
    assign o_hit.point_x = b_pt[0];
    assign o_hit.point_y = b_pt[1];
    assign o_hit.point_z = b_pt[2];
endmodule
`default_nettype wire
